[rtl/core/lsc_pkg.sv]
package lsc_pkg;

  // Default number of fraction bits of the position error.
  localparam int FRAC_BITS_DEF = 8;

  // Widths of the fixed fields of the result.
  localparam int POS_ERR_W = 12;
  localparam int DELTA_W   = 13;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Request kinds, carried on in_tuser.
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_RESYNC = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_WHITE_TICKS     = 3'd0;
  localparam logic [2:0] REG_HAS_BLACK_TICKS = 3'd1;
  localparam logic [2:0] REG_ALL_BLACK_TICKS = 3'd2;
  localparam logic [2:0] REG_NOT_BLACK_TICKS = 3'd3;
  localparam logic [2:0] REG_WHITE_COOLDOWN  = 3'd4;
  localparam logic [2:0] REG_BLACK_COOLDOWN  = 3'd5;
  localparam logic [2:0] REG_DEAD_BAND       = 3'd6;

  // Register reset values.
  localparam logic [7:0]  RST_WHITE_TICKS     = 8'd3;
  localparam logic [7:0]  RST_HAS_BLACK_TICKS = 8'd2;
  localparam logic [7:0]  RST_ALL_BLACK_TICKS = 8'd2;
  localparam logic [7:0]  RST_NOT_BLACK_TICKS = 8'd2;
  localparam logic [7:0]  RST_WHITE_COOLDOWN  = 8'd4;
  localparam logic [7:0]  RST_BLACK_COOLDOWN  = 8'd4;
  localparam logic [10:0] RST_DEAD_BAND       = 11'd77;

  // Event bit positions.
  localparam int EVT_W2B         = 0;
  localparam int EVT_B2W         = 1;
  localparam int EVT_ENTER_BLACK = 2;
  localparam int EVT_EXIT_BLACK  = 3;

  localparam logic [7:0] RUN_MAX     = 8'hFF;
  localparam logic [2:0] SENSORS_ALL = 3'd5;

  typedef struct packed {
    logic [7:0]  white_ticks;
    logic [7:0]  has_black_ticks;
    logic [7:0]  all_black_ticks;
    logic [7:0]  not_black_ticks;
    logic [7:0]  white_cooldown;
    logic [7:0]  black_cooldown;
    logic [10:0] dead_band;
  } lsc_cfg_t;

  typedef struct packed {
    logic       stable_white;
    logic       stable_black;
    logic [3:0] event_flags;
  } lsc_dbn_t;

  // Number of black sensors in a five-bit pattern.
  function automatic logic [2:0] pop5(input logic [4:0] p);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 5; i++) begin
      n = n + {2'b00, p[i]};
    end
    return n;
  endfunction

  // Sum of the sensor weights -4, -2, 0, 2, 4 over the black sensors.
  function automatic int weight_sum(input logic [4:0] p);
    int s;
    s = 0;
    for (int i = 0; i < 5; i++) begin
      if (p[i]) begin
        s = s + 2 * i - 4;
      end
    end
    return s;
  endfunction

endpackage

[rtl/core/line_sensor_conditioner_core.sv]
// Five-channel line sensor conditioner.
//
// Requests arrive on the in_ stream: in_tuser carries the request kind (sample, resync,
// pop flags, clear flags by mask) and in_tdata the sensor bits and the clear mask. Each
// request yields exactly one result on the out_ stream, carrying the raw pattern, black
// count, position error in signed fixed point, error difference, last-seen side, the
// debounced white and all-black states and the latched edge events.
// Thresholds, cooldowns and the centre dead band sit in an APB register file on the cfg_
// port; they should only be written while no request is in flight.
//
// A request passes from the input register through the error table, debounce counters
// and event logic into the result register. A new request is taken every cycle, limited
// only by the single result register: while a result waits, one further request is still
// accepted into the input register, and in_tready falls only when both are full and
// out_tready is low.
// A synchronous reset (rst_n low) empties both registers, restores the register defaults
// and returns the tracking state to all-white with no events pending.
module line_sensor_conditioner_core #(
  parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: sensor_bits[4:0], clear_mask[8:5], zero padding above
  input  logic [lsc_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode[1:0]
  input  logic [lsc_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // out_tdata: raw_pattern[4:0], black_count[7:5], raw_white[8], raw_black[9],
  // position_error[21:10], error_delta[34:22], seen_side[36:35], stable_white[37],
  // stable_black[38], event_flags[42:39], zero padding above
  output logic [lsc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lsc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lsc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import lsc_pkg::*;

  localparam int ERR_W = FRAC_BITS + 4;

  lsc_cfg_t cfg;
  lsc_dbn_t dbn;

  // Input register.
  logic       s1_v_r;
  logic [1:0] s1_mode_r;
  logic [4:0] s1_sensors_r;
  logic [3:0] s1_mask_r;

  // Result register.
  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [4:0] last_pattern_r, last_pattern_nxt;

  logic                    advance;
  logic                    fire;
  logic                    sample_op;
  logic signed [ERR_W-1:0] err_nxt;
  logic signed [ERR_W:0]   delta;
  logic [1:0]              side_nxt;
  logic [2:0]              cnt;
  logic [POS_ERR_W-1:0]    pos_err_f;
  logic [DELTA_W-1:0]      delta_f;

  // The result register moves on when empty or taken; the input register
  // drains into it whenever it moves.
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || advance;
  assign fire      = s1_v_r && advance;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  lsc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lsc_position #(
    .FRAC_BITS (FRAC_BITS)
  ) u_position (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .mode      (s1_mode_r),
    .sensors   (s1_sensors_r),
    .dead_band (cfg.dead_band),
    .err_nxt   (err_nxt),
    .delta     (delta),
    .side_nxt  (side_nxt)
  );

  lsc_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .mode       (s1_mode_r),
    .sensors    (s1_sensors_r),
    .clear_mask (s1_mask_r),
    .cfg        (cfg),
    .status     (dbn)
  );

  // Pop and clear requests take no sample, so the raw fields repeat the
  // previous pattern.
  assign sample_op        = (s1_mode_r == MODE_SAMPLE) || (s1_mode_r == MODE_RESYNC);
  assign last_pattern_nxt = sample_op ? s1_sensors_r : last_pattern_r;
  assign cnt              = pop5(last_pattern_nxt);

  // Sign-extend or truncate the error to the fixed result widths.
  assign pos_err_f = POS_ERR_W'(err_nxt);
  assign delta_f   = DELTA_W'(delta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      last_pattern_r <= 5'd0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= s1_v_r;
      end
      if (fire) begin
        last_pattern_r <= last_pattern_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r    <= in_tuser[1:0];
      s1_sensors_r <= in_tdata[4:0];
      s1_mask_r    <= in_tdata[8:5];
    end
    if (fire) begin
      out_data_r <= {5'd0, dbn.event_flags, dbn.stable_black, dbn.stable_white,
                     side_nxt, delta_f, pos_err_f, (cnt == SENSORS_ALL), (cnt == 3'd0),
                     cnt, last_pattern_nxt};
    end
  end

endmodule

[rtl/core/lsc_cfg.sv]
module lsc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [lsc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lsc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready,
  output lsc_pkg::lsc_cfg_t            cfg
);
  import lsc_pkg::*;

  lsc_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.white_ticks     <= RST_WHITE_TICKS;
      cfg_r.has_black_ticks <= RST_HAS_BLACK_TICKS;
      cfg_r.all_black_ticks <= RST_ALL_BLACK_TICKS;
      cfg_r.not_black_ticks <= RST_NOT_BLACK_TICKS;
      cfg_r.white_cooldown  <= RST_WHITE_COOLDOWN;
      cfg_r.black_cooldown  <= RST_BLACK_COOLDOWN;
      cfg_r.dead_band       <= RST_DEAD_BAND;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WHITE_TICKS:     cfg_r.white_ticks     <= cfg_pwdata[7:0];
        REG_HAS_BLACK_TICKS: cfg_r.has_black_ticks <= cfg_pwdata[7:0];
        REG_ALL_BLACK_TICKS: cfg_r.all_black_ticks <= cfg_pwdata[7:0];
        REG_NOT_BLACK_TICKS: cfg_r.not_black_ticks <= cfg_pwdata[7:0];
        REG_WHITE_COOLDOWN:  cfg_r.white_cooldown  <= cfg_pwdata[7:0];
        REG_BLACK_COOLDOWN:  cfg_r.black_cooldown  <= cfg_pwdata[7:0];
        REG_DEAD_BAND:       cfg_r.dead_band       <= cfg_pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WHITE_TICKS:     cfg_prdata = {24'd0, cfg_r.white_ticks};
      REG_HAS_BLACK_TICKS: cfg_prdata = {24'd0, cfg_r.has_black_ticks};
      REG_ALL_BLACK_TICKS: cfg_prdata = {24'd0, cfg_r.all_black_ticks};
      REG_NOT_BLACK_TICKS: cfg_prdata = {24'd0, cfg_r.not_black_ticks};
      REG_WHITE_COOLDOWN:  cfg_prdata = {24'd0, cfg_r.white_cooldown};
      REG_BLACK_COOLDOWN:  cfg_prdata = {24'd0, cfg_r.black_cooldown};
      REG_DEAD_BAND:       cfg_prdata = {21'd0, cfg_r.dead_band};
      default:             cfg_prdata = '0;
    endcase
  end

endmodule

[rtl/core/lsc_position.sv]
module lsc_position #(
  parameter int FRAC_BITS = lsc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [1:0]                  mode,
  input  logic [4:0]                  sensors,
  input  logic [10:0]                 dead_band,
  output logic signed [FRAC_BITS+3:0] err_nxt,
  output logic signed [FRAC_BITS+4:0] delta,
  output logic [1:0]                  side_nxt
);
  import lsc_pkg::*;

  localparam int ERR_W = FRAC_BITS + 4;
  localparam int DW    = ERR_W + 1;
  localparam int CMP_W = ((ERR_W > 12) ? ERR_W : 12) + 1;

  // Rounded quotient for every pattern, worked out at elaboration.
  logic signed [ERR_W-1:0] err_tab [32];

  for (genvar gi = 0; gi < 32; gi++) begin : g_tab
    localparam int WSUM = weight_sum(5'(gi));
    localparam int CNT0 = int'(pop5(5'(gi)));
    localparam int CNT  = (CNT0 == 0) ? 1 : CNT0;
    localparam int MAG  = (WSUM < 0) ? -WSUM : WSUM;
    localparam int QMAG = ((MAG << FRAC_BITS) + CNT / 2) / CNT;
    assign err_tab[gi] = ERR_W'((WSUM < 0) ? -QMAG : QMAG);
  end

  logic signed [ERR_W-1:0] held_r;
  logic [1:0]              side_r;
  logic signed [ERR_W-1:0] held_base;
  logic [1:0]              side_base;
  logic signed [ERR_W-1:0] err_sample;
  logic signed [CMP_W-1:0] err_x;
  logic signed [CMP_W-1:0] band_x;
  logic                    sample_op;
  logic                    any_black;

  assign sample_op  = (mode == MODE_SAMPLE) || (mode == MODE_RESYNC);
  assign any_black  = |sensors;
  assign err_sample = err_tab[sensors];
  assign held_base  = (mode == MODE_RESYNC) ? '0 : held_r;
  assign side_base  = (mode == MODE_RESYNC) ? 2'b00 : side_r;
  assign err_x      = CMP_W'(err_sample);
  assign band_x     = $signed({{(CMP_W - 11){1'b0}}, dead_band});

  always_comb begin
    err_nxt  = held_r;
    side_nxt = side_r;
    delta    = '0;
    if (sample_op) begin
      err_nxt  = held_base;
      side_nxt = side_base;
      if (any_black) begin
        err_nxt = err_sample;
        if (err_x > band_x) begin
          side_nxt = 2'b01;
        end else if (err_x < -band_x) begin
          side_nxt = 2'b11;
        end
      end
      delta = DW'(err_nxt) - DW'(held_base);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      side_r <= 2'b00;
    end else if (fire) begin
      held_r <= err_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

[rtl/core/lsc_debounce.sv]
module lsc_debounce (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [1:0]        mode,
  input  logic [4:0]        sensors,
  input  logic [3:0]        clear_mask,
  input  lsc_pkg::lsc_cfg_t cfg,
  output lsc_pkg::lsc_dbn_t status
);
  import lsc_pkg::*;

  logic [7:0] wrun_r, wrun_nxt;
  logic [7:0] sbrun_r, sbrun_nxt;
  logic [7:0] brun_r, brun_nxt;
  logic [7:0] nbrun_r, nbrun_nxt;
  logic [7:0] wcd_r, wcd_nxt;
  logic [7:0] bcd_r, bcd_nxt;
  logic       sw_r, sw_nxt;
  logic       sb_r, sb_nxt;
  logic [3:0] ev_r, ev_nxt;
  logic [2:0] cnt;
  logic       all_white;
  logic       all_black;

  assign cnt       = pop5(sensors);
  assign all_white = (cnt == 3'd0);
  assign all_black = (cnt == SENSORS_ALL);

  always_comb begin
    wrun_nxt  = wrun_r;
    sbrun_nxt = sbrun_r;
    brun_nxt  = brun_r;
    nbrun_nxt = nbrun_r;
    wcd_nxt   = wcd_r;
    bcd_nxt   = bcd_r;
    sw_nxt    = sw_r;
    sb_nxt    = sb_r;
    ev_nxt    = ev_r;
    case (mode)
      MODE_SAMPLE: begin
        wcd_nxt = (wcd_r != 8'd0) ? wcd_r - 8'd1 : 8'd0;
        bcd_nxt = (bcd_r != 8'd0) ? bcd_r - 8'd1 : 8'd0;

        if (all_white) begin
          wrun_nxt  = (wrun_r != RUN_MAX) ? wrun_r + 8'd1 : wrun_r;
          sbrun_nxt = 8'd0;
        end else begin
          sbrun_nxt = (sbrun_r != RUN_MAX) ? sbrun_r + 8'd1 : sbrun_r;
          wrun_nxt  = 8'd0;
        end
        if (wrun_nxt >= cfg.white_ticks) begin
          sw_nxt = 1'b1;
        end else if (sbrun_nxt >= cfg.has_black_ticks) begin
          sw_nxt = 1'b0;
        end
        if ((sw_nxt != sw_r) && (wcd_nxt == 8'd0)) begin
          if (sw_r) begin
            ev_nxt[EVT_W2B] = 1'b1;
          end else begin
            ev_nxt[EVT_B2W] = 1'b1;
          end
          wcd_nxt = cfg.white_cooldown;
        end

        if (all_black) begin
          brun_nxt  = (brun_r != RUN_MAX) ? brun_r + 8'd1 : brun_r;
          nbrun_nxt = 8'd0;
        end else begin
          nbrun_nxt = (nbrun_r != RUN_MAX) ? nbrun_r + 8'd1 : nbrun_r;
          brun_nxt  = 8'd0;
        end
        if (brun_nxt >= cfg.all_black_ticks) begin
          sb_nxt = 1'b1;
        end else if (nbrun_nxt >= cfg.not_black_ticks) begin
          sb_nxt = 1'b0;
        end
        if ((sb_nxt != sb_r) && (bcd_nxt == 8'd0)) begin
          if (sb_nxt) begin
            ev_nxt[EVT_ENTER_BLACK] = 1'b1;
          end else begin
            ev_nxt[EVT_EXIT_BLACK] = 1'b1;
          end
          bcd_nxt = cfg.black_cooldown;
        end
      end
      MODE_RESYNC: begin
        wrun_nxt  = 8'd0;
        sbrun_nxt = 8'd0;
        brun_nxt  = 8'd0;
        nbrun_nxt = 8'd0;
        wcd_nxt   = 8'd0;
        bcd_nxt   = 8'd0;
        sw_nxt    = all_white;
        sb_nxt    = all_black;
        ev_nxt    = 4'd0;
      end
      MODE_POP: begin
        ev_nxt = 4'd0;
      end
      MODE_CLEAR: begin
        ev_nxt = ev_r & ~clear_mask;
      end
      default: begin
      end
    endcase
  end

  // A pop shows the flags as they stood before clearing.
  assign status.stable_white = sw_nxt;
  assign status.stable_black = sb_nxt;
  assign status.event_flags  = (mode == MODE_POP) ? ev_r : ev_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrun_r  <= 8'd0;
      sbrun_r <= 8'd0;
      brun_r  <= 8'd0;
      nbrun_r <= 8'd0;
      wcd_r   <= 8'd0;
      bcd_r   <= 8'd0;
      sw_r    <= 1'b1;
      sb_r    <= 1'b0;
      ev_r    <= 4'd0;
    end else if (fire) begin
      wrun_r  <= wrun_nxt;
      sbrun_r <= sbrun_nxt;
      brun_r  <= brun_nxt;
      nbrun_r <= nbrun_nxt;
      wcd_r   <= wcd_nxt;
      bcd_r   <= bcd_nxt;
      sw_r    <= sw_nxt;
      sb_r    <= sb_nxt;
      ev_r    <= ev_nxt;
    end
  end

endmodule

[rtl/core/lsc_checker.sv]
module lsc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [lsc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic                           cfg_pready
);
  import lsc_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Requests are only refused while the result side is stalled.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("request refused without a stalled result");

  // A request taken while no result is waiting reaches out_tvalid through the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("result missing two cycles after request");

  // Reset empties the result channel and the register port stays ready.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && cfg_pready)
    else $error("result valid or port not ready after reset");

endmodule

bind line_sensor_conditioner_core lsc_checker u_lsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_pready (cfg_pready)
);

[tb/tb_line_sensor_conditioner_core.sv]
module tb_line_sensor_conditioner_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lsc_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int CYCLE_CAP  = 300000;
  localparam int PRINT_CAP  = 100;
  localparam int NUM_PHASES = 6;

  // One request as it is queued for the driver.
  typedef struct {
    logic [1:0] mode;
    logic [4:0] bits;
    logic [3:0] mask;
  } request_t;

  // One result, laid out so that the first field of out_tdata sits in the lowest bits.
  typedef struct packed {
    logic [3:0]         event_flags;
    logic               stable_black;
    logic               stable_white;
    logic signed [1:0]  seen_side;
    logic signed [12:0] error_delta;
    logic signed [11:0] position_error;
    logic               raw_black;
    logic               raw_white;
    logic [2:0]         black_count;
    logic [4:0]         raw_pattern;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic [IN_USER_W-1:0]  in_tuser    = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  line_sensor_conditioner_core #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Requests waiting to be driven, and the results predicted for accepted requests.
  request_t sensor_requests[$];
  result_t  predicted_results[$];

  // Bookkeeping for the summary and the verdict.
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int mode_counts[4] = '{0, 0, 0, 0};
  int events_seen = 0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  // ---------------------------------------------------------------------------------------
  // Predictor. It keeps a mirror of the register file and its own copy of the tracking
  // state, and steps the tracking state once per accepted request.
  // ---------------------------------------------------------------------------------------
  logic [7:0]  thr_white, thr_dark, thr_full, thr_partial, cool_white, cool_black;
  logic [10:0] dead_band;

  int                err_hold;
  logic signed [1:0] side_q;
  logic              st_white, st_black;
  int                run_white, run_dark, run_full, run_partial;
  int                cd_white, cd_black;
  logic [3:0]        evt_q;
  logic [4:0]        pat_q;

  function automatic int black_total(input logic [4:0] p);
    int n;
    n = 0;
    for (int i = 0; i < 5; i++) n += p[i];
    return n;
  endfunction

  // Weighted centroid of the black sensors, rounded to nearest with ties away from zero.
  function automatic int centroid_error(input logic [4:0] p, input int n);
    int weights[5] = '{-4, -2, 0, 2, 4};
    int acc, num, mag, q;
    acc = 0;
    for (int i = 0; i < 5; i++) begin
      if (p[i]) acc += weights[i];
    end
    num = acc * (1 << FRAC);
    mag = (num < 0) ? -num : num;
    q   = (mag + n / 2) / n;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void clear_tracking();
    err_hold  = 0;
    side_q    = 2'sd0;
    st_white  = 1'b1;
    st_black  = 1'b0;
    run_white = 0;
    run_dark  = 0;
    run_full  = 0;
    run_partial = 0;
    cd_white  = 0;
    cd_black  = 0;
    evt_q     = '0;
    pat_q     = '0;
  endfunction

  // Latches the sample, moves the error and the side; returns the change in error.
  function automatic int take_reading(input logic [4:0] p);
    int prev, n, e;
    prev  = err_hold;
    n     = black_total(p);
    pat_q = p;
    if (n > 0) begin
      e = centroid_error(p, n);
      err_hold = e;
      if (e > int'(dead_band)) side_q = 2'sd1;
      else if (e < -int'(dead_band)) side_q = -2'sd1;
    end
    return err_hold - prev;
  endfunction

  function automatic void step_debounce();
    int   n;
    logic pw, pb;
    n  = black_total(pat_q);
    pw = st_white;
    pb = st_black;
    if (cd_white > 0) cd_white--;
    if (cd_black > 0) cd_black--;

    if (n == 0) begin
      if (run_white < 255) run_white++;
      run_dark = 0;
    end else begin
      if (run_dark < 255) run_dark++;
      run_white = 0;
    end
    if (run_white >= int'(thr_white)) st_white = 1'b1;
    else if (run_dark >= int'(thr_dark)) st_white = 1'b0;
    if (pw != st_white && cd_white == 0) begin
      evt_q[pw ? EVT_W2B : EVT_B2W] = 1'b1;
      cd_white = int'(cool_white);
    end

    if (n == 5) begin
      if (run_full < 255) run_full++;
      run_partial = 0;
    end else begin
      if (run_partial < 255) run_partial++;
      run_full = 0;
    end
    if (run_full >= int'(thr_full)) st_black = 1'b1;
    else if (run_partial >= int'(thr_partial)) st_black = 1'b0;
    if (pb != st_black && cd_black == 0) begin
      evt_q[st_black ? EVT_ENTER_BLACK : EVT_EXIT_BLACK] = 1'b1;
      cd_black = int'(cool_black);
    end
  endfunction

  function automatic result_t condition_request(input request_t rq);
    result_t    rs;
    int         delta, n;
    logic [3:0] shown;
    delta = 0;
    case (rq.mode)
      MODE_SAMPLE: begin
        delta = take_reading(rq.bits);
        step_debounce();
        shown = evt_q;
      end
      MODE_RESYNC: begin
        // Everything restarts from the reset state; the flags follow the raw sample.
        clear_tracking();
        delta    = take_reading(rq.bits);
        n        = black_total(rq.bits);
        st_white = (n == 0);
        st_black = (n == 5);
        shown    = evt_q;
      end
      MODE_POP: begin
        shown = evt_q;
        evt_q = '0;
      end
      default: begin
        evt_q = evt_q & ~rq.mask;
        shown = evt_q;
      end
    endcase
    n = black_total(pat_q);
    rs.raw_pattern    = pat_q;
    rs.black_count    = n[2:0];
    rs.raw_white      = (n == 0);
    rs.raw_black      = (n == 5);
    rs.position_error = err_hold[11:0];
    rs.error_delta    = delta[12:0];
    rs.seen_side      = side_q;
    rs.stable_white   = st_white;
    rs.stable_black   = st_black;
    rs.event_flags    = shown;
    return rs;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver. Presents the oldest queued request, holds it until the block takes it, and
  // inserts random idle bursts between requests unless the run is calm.
  // The prediction is made at the very edge at which the request is accepted.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted_results.push_back(condition_request(sensor_requests[0]));
        mode_counts[sensor_requests[0].mode]++;
        sensor_requests.pop_front();
      end
      if (in_tvalid && !in_tready) begin
        // A presented request stays on the bus untouched until it is taken.
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        in_gap = $urandom_range(0, 3);
        in_tvalid <= 1'b0;
      end else if (sensor_requests.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser  <= sensor_requests[0].mode;
        in_tdata  <= {{(IN_DATA_W - 9){1'b0}}, sensor_requests[0].mask,
                      sensor_requests[0].bits};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor. Takes each result at its handshake, compares every field with the oldest
  // prediction, and stalls the result channel in random bursts.
  // ---------------------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input int got, input int want);
    // Printing stops after a while so that a badly broken block cannot flood the log.
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] result %0d, %s: got %0d, expected %0d",
               $realtime, results_seen, field, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[RESULT_W-1:0];
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result, raw_pattern", int'(got.raw_pattern), -1);
        end else begin
          want = predicted_results.pop_front();
          if (got.raw_pattern != want.raw_pattern)
            report_mismatch("raw_pattern", int'(got.raw_pattern), int'(want.raw_pattern));
          if (got.black_count != want.black_count)
            report_mismatch("black_count", int'(got.black_count), int'(want.black_count));
          if (got.raw_white != want.raw_white)
            report_mismatch("raw_white", int'(got.raw_white), int'(want.raw_white));
          if (got.raw_black != want.raw_black)
            report_mismatch("raw_black", int'(got.raw_black), int'(want.raw_black));
          if (got.position_error != want.position_error)
            report_mismatch("position_error", int'(got.position_error),
                            int'(want.position_error));
          if (got.error_delta != want.error_delta)
            report_mismatch("error_delta", int'(got.error_delta), int'(want.error_delta));
          if (got.seen_side != want.seen_side)
            report_mismatch("seen_side", int'(got.seen_side), int'(want.seen_side));
          if (got.stable_white != want.stable_white)
            report_mismatch("stable_white", int'(got.stable_white),
                            int'(want.stable_white));
          if (got.stable_black != want.stable_black)
            report_mismatch("stable_black", int'(got.stable_black),
                            int'(want.stable_black));
          if (got.event_flags != want.event_flags)
            report_mismatch("event_flags", int'(got.event_flags), int'(want.event_flags));
          if (out_tdata[OUT_DATA_W-1:RESULT_W] != '0)
            report_mismatch("padding", int'(out_tdata[OUT_DATA_W-1:RESULT_W]), 0);
          if (want.event_flags != '0) events_seen++;
        end
        results_seen++;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Timed out after %0d cycles with %0d requests queued, %0d results awaited.",
               cycle_count, sensor_requests.size(), predicted_results.size());
      $display("tb_line_sensor_conditioner_core: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Register writes: a setup phase, then an access phase held until pready. The mirror
  // takes the new value once the write has gone through.
  // ---------------------------------------------------------------------------------------
  task automatic write_register(input logic [2:0] index, input int unsigned value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (index)
      REG_WHITE_TICKS:     thr_white   = value[7:0];
      REG_HAS_BLACK_TICKS: thr_dark    = value[7:0];
      REG_ALL_BLACK_TICKS: thr_full    = value[7:0];
      REG_NOT_BLACK_TICKS: thr_partial = value[7:0];
      REG_WHITE_COOLDOWN:  cool_white  = value[7:0];
      REG_BLACK_COOLDOWN:  cool_black  = value[7:0];
      default:             dead_band   = value[10:0];
    endcase
  endtask

  // Writes all seven registers for a phase: minima, maxima with the dead band at the error
  // limit, always-met thresholds with a dead band past it, then random mid-range settings.
  task automatic apply_setting(input int phase);
    int unsigned v[7];
    case (phase)
      1: v = '{1, 1, 1, 1, 0, 0, 0};
      2: v = '{255, 255, 255, 255, 255, 255, 1024};
      3: v = '{0, 0, 0, 0, 1, 0, 2047};
      default: begin
        for (int i = 0; i < 4; i++) v[i] = $urandom_range(1, 12);
        v[4] = $urandom_range(0, 10);
        v[5] = $urandom_range(0, 10);
        v[6] = $urandom_range(0, 1024);
      end
    endcase
    write_register(REG_WHITE_TICKS,     v[0]);
    write_register(REG_HAS_BLACK_TICKS, v[1]);
    write_register(REG_ALL_BLACK_TICKS, v[2]);
    write_register(REG_NOT_BLACK_TICKS, v[3]);
    write_register(REG_WHITE_COOLDOWN,  v[4]);
    write_register(REG_BLACK_COOLDOWN,  v[5]);
    write_register(REG_DEAD_BAND,       v[6]);
  endtask

  function automatic void queue_request(input logic [1:0] mode, input logic [4:0] bits,
                                        input logic [3:0] mask);
    request_t rq;
    rq.mode = mode;
    rq.bits = bits;
    rq.mask = mask;
    sensor_requests.push_back(rq);
  endfunction

  // Random traffic is mostly runs of one kind of reading (all white, all black or a
  // partly covered line) so that the debounce counters reach their thresholds; resyncs,
  // pops and masked clears are sprinkled in. Long runs appear now and then to drive the
  // run counters into saturation.
  task automatic queue_random_traffic(input int count, input int longest_run);
    int         made, pick, kind, len;
    logic [4:0] bits;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_request(MODE_RESYNC, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
        made++;
      end else if (pick < 13) begin
        queue_request(MODE_POP, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
        made++;
      end else if (pick < 20) begin
        queue_request(MODE_CLEAR, 5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)));
        made++;
      end else begin
        kind = $urandom_range(0, 9);
        len  = ($urandom_range(0, 19) == 0) ? $urandom_range(1, longest_run)
                                            : $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          if (kind < 3) bits = 5'h00;
          else if (kind < 6) bits = 5'h1F;
          else bits = 5'($urandom_range(1, 30));
          queue_request(MODE_SAMPLE, bits, 4'($urandom_range(0, 15)));
        end
        made += len;
      end
    end
  endtask

  task automatic wait_until_drained();
    while (sensor_requests.size() != 0 || predicted_results.size() != 0 || in_tvalid)
      @(posedge clk);
    // Two register stages sit between a request and its result; allow a little more.
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequencing: reset, a directed opening at the reset settings, then random phases,
  // each under a fresh register setting written while the block is idle.
  // ---------------------------------------------------------------------------------------
  initial begin
    thr_white   = RST_WHITE_TICKS;
    thr_dark    = RST_HAS_BLACK_TICKS;
    thr_full    = RST_ALL_BLACK_TICKS;
    thr_partial = RST_NOT_BLACK_TICKS;
    cool_white  = RST_WHITE_COOLDOWN;
    cool_black  = RST_BLACK_COOLDOWN;
    dead_band   = RST_DEAD_BAND;
    clear_tracking();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: a white reading, two black ones to flip both debounced states,
    // every single sensor, off-centre groups whose centroid needs rounding, a white run
    // back to stable white after the cooldown has run out, then pops, masked clears and resyncs.
    queue_request(MODE_SAMPLE, 5'h00, 4'h0);
    queue_request(MODE_SAMPLE, 5'h1F, 4'hF);
    queue_request(MODE_SAMPLE, 5'h1F, 4'h0);
    queue_request(MODE_POP,    5'h1F, 4'hF);
    queue_request(MODE_SAMPLE, 5'h01, 4'h1);
    queue_request(MODE_SAMPLE, 5'h02, 4'h2);
    queue_request(MODE_SAMPLE, 5'h04, 4'h4);
    queue_request(MODE_SAMPLE, 5'h08, 4'h8);
    queue_request(MODE_SAMPLE, 5'h10, 4'h0);
    queue_request(MODE_SAMPLE, 5'h07, 4'h0);
    queue_request(MODE_SAMPLE, 5'h0D, 4'h0);
    queue_request(MODE_SAMPLE, 5'h1A, 4'h0);
    queue_request(MODE_SAMPLE, 5'h00, 4'h0);
    queue_request(MODE_SAMPLE, 5'h00, 4'h0);
    queue_request(MODE_SAMPLE, 5'h00, 4'h0);
    queue_request(MODE_CLEAR,  5'h00, 4'h5);
    queue_request(MODE_POP,    5'h00, 4'h0);
    queue_request(MODE_RESYNC, 5'h1F, 4'h0);
    queue_request(MODE_RESYNC, 5'h00, 4'h0);
    queue_request(MODE_RESYNC, 5'h0B, 4'h0);
    queue_request(MODE_SAMPLE, 5'h18, 4'h0);
    queue_request(MODE_CLEAR,  5'h18, 4'hF);
    queue_request(MODE_SAMPLE, 5'h03, 4'h0);
    queue_random_traffic(60, 12);
    wait_until_drained();

    for (int phase = 1; phase <= NUM_PHASES; phase++) begin
      apply_setting(phase);
      // The final phase runs back to back on both channels.
      if (phase == NUM_PHASES) calm = 1'b1;
      queue_random_traffic(320, (phase == 2) ? 300 : 24);
      wait_until_drained();
    end

    $display("Checked %0d results under %0d register settings; %0d carried events.",
             results_seen, NUM_PHASES + 1, events_seen);
    $display("Requests: %0d samples, %0d resyncs, %0d pops, %0d masked clears.",
             mode_counts[MODE_SAMPLE], mode_counts[MODE_RESYNC],
             mode_counts[MODE_POP], mode_counts[MODE_CLEAR]);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("tb_line_sensor_conditioner_core: PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived.",
               mismatches, predicted_results.size());
      $display("tb_line_sensor_conditioner_core: FAIL");
    end
    $finish;
  end

endmodule
